// ----- rtl/qghc_pkg.sv -----
// ----------------------------------------------------------------------------
// qghc_pkg
// Shared widths and latency constants of the quad geometric hash code core.
// ----------------------------------------------------------------------------
`default_nettype none

package qghc_pkg;

    localparam int COORD_W  = 20;   // unsigned 16.4 pixel coordinate
    localparam int DIFF_W   = 21;   // signed coordinate difference
    localparam int ROT_W    = 22;   // signed rotation term (ABy +/- ABx)
    localparam int PROD_W   = 43;   // signed product of a difference and a rotation term
    localparam int SQ_W     = 42;   // signed square of a difference
    localparam int NUM_W    = 44;   // signed numerator
    localparam int DEN_W    = 43;   // unsigned |AB| squared
    localparam int CODE_W   = 24;   // signed code output
    localparam int QB       = CODE_W + 1;   // quotient bits, one extra for rounding
    localparam int NUM_PAIR = 3;    // stars C, D and E
    localparam int STARS_W  = 3;

    localparam logic [CODE_W-1:0] CODE_MAX = {1'b0, {(CODE_W-1){1'b1}}};
    localparam logic [CODE_W-1:0] CODE_MIN = {1'b1, {(CODE_W-1){1'b0}}};

    // divider: magnitude stage, range check stage, QB quotient steps, round stage
    localparam int DIV_LAT  = QB + 3;
    // front end: differences, rotation terms, products, sums
    localparam int FRONT_LAT = 4;

    localparam logic [STARS_W-1:0] STARS_MIN   = 3'd3;
    localparam logic [STARS_W-1:0] STARS_RESET = 3'd4;

endpackage : qghc_pkg

`default_nettype wire

// ----- rtl/quad_geometric_hash_code_core.sv -----
// ----------------------------------------------------------------------------
// quad_geometric_hash_code_core
// Geometric hash code of a star quad: stars C, D and E expressed in the
// similarity frame set by stars A and B, in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat per quad, ten 20-bit unsigned 16.4 coordinates.
//   Master stream: one beat per quad, six 24-bit signed codes in tdata and
//   the degenerate flag (A equals B) in tuser. Codes of stars not in use and
//   all codes of a degenerate quad are zero.
//   Config channel: 3-bit stars_in_use (3..MAX_STARS, clamped), always ready;
//   write it only while no quad is in flight.
// Pipeline and throughput:
//   Four front-end stages (differences, rotation terms, products, sums) and
//   28 divider stages (magnitude, range check, 25 one-bit quotient steps,
//   round). One quad is accepted every cycle unless the output stalls.
// Reset:
//   synchronous, active low; clears all valid bits and sets stars_in_use to 4.
// Stall:
//   the whole pipeline holds while the output beat is valid and not taken;
//   o_s_axis_tready drops for those cycles. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_geometric_hash_code_core
    import qghc_pkg::*;
#(
    parameter int MAX_STARS      = 5,
    parameter int CODE_FRAC_BITS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,

    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [STARS_W-1:0]  i_cfg_data,

    input  wire                 i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // ax, ay, bx, by_coord, cx, cy, dx, dy, ex, ey (20 bits each)
    input  wire  [199:0]        i_s_axis_tdata,

    output logic                o_m_axis_tvalid,
    input  wire                 i_m_axis_tready,
    // code_cx, code_cy, code_dx, code_dy, code_ex, code_ey (24 bits each)
    output logic [143:0]        o_m_axis_tdata,
    // degenerate
    output logic [0:0]          o_m_axis_tuser
);

    localparam int LAT = FRONT_LAT + DIV_LAT;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [STARS_W-1:0] r_stars;
    logic [STARS_W-1:0] n_stars_eff;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stars <= STARS_RESET;
        end else if (i_cfg_valid) begin
            r_stars <= i_cfg_data;
        end
    end

    // clamp to the supported range
    always_comb begin
        n_stars_eff = r_stars;
        if (r_stars < STARS_MIN) begin
            n_stars_eff = STARS_MIN;
        end
        if (r_stars > STARS_W'(MAX_STARS)) begin
            n_stars_eff = STARS_W'(MAX_STARS);
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together
    // ------------------------------------------------------------------
    logic           w_en;
    logic           w_in_fire;
    logic [LAT-1:0] r_vld;
    logic [STARS_W-1:0] r_n_pipe   [0:LAT-1];
    logic               r_deg_pipe [0:LAT-1];

    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign w_in_fire       = i_s_axis_tvalid && w_en;
    assign o_m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], w_in_fire};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: differences to star A
    // ------------------------------------------------------------------
    logic [COORD_W-1:0]        w_c [0:9];
    logic signed [DIFF_W-1:0]  r_abx, r_aby;
    logic signed [DIFF_W-1:0]  r_px [0:NUM_PAIR-1];
    logic signed [DIFF_W-1:0]  r_py [0:NUM_PAIR-1];
    logic [DIFF_W-1:0]         w_abx, w_aby;

    for (genvar f = 0; f < 10; f++) begin : g_field
        assign w_c[f] = i_s_axis_tdata[f*COORD_W +: COORD_W];
    end

    assign w_abx = {1'b0, w_c[2]} - {1'b0, w_c[0]};
    assign w_aby = {1'b0, w_c[3]} - {1'b0, w_c[1]};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_abx         <= w_abx;
            r_aby         <= w_aby;
            r_n_pipe[0]   <= n_stars_eff;
            r_deg_pipe[0] <= (w_abx == '0) && (w_aby == '0);
        end
    end

    for (genvar j = 0; j < NUM_PAIR; j++) begin : g_diff
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_px[j] <= {1'b0, w_c[4+2*j]} - {1'b0, w_c[0]};
                r_py[j] <= {1'b0, w_c[5+2*j]} - {1'b0, w_c[1]};
            end
        end
    end

    // carry the star count and degenerate flag alongside the data
    for (genvar m = 1; m < LAT; m++) begin : g_meta
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_n_pipe[m]   <= r_n_pipe[m-1];
                r_deg_pipe[m] <= r_deg_pipe[m-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: rotation terms; Stage 3: products; Stage 4: sums
    // ------------------------------------------------------------------
    logic signed [ROT_W-1:0]  r_cs, r_sn;
    logic signed [DIFF_W-1:0] r_abx2, r_aby2;
    logic signed [DIFF_W-1:0] r_px2 [0:NUM_PAIR-1];
    logic signed [DIFF_W-1:0] r_py2 [0:NUM_PAIR-1];
    logic signed [SQ_W-1:0]   r_sqx, r_sqy;
    logic [DEN_W-1:0]         r_den;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cs   <= ROT_W'(r_aby) + ROT_W'(r_abx);
            r_sn   <= ROT_W'(r_aby) - ROT_W'(r_abx);
            r_abx2 <= r_abx;
            r_aby2 <= r_aby;
            r_sqx  <= r_abx2 * r_abx2;
            r_sqy  <= r_aby2 * r_aby2;
            r_den  <= DEN_W'($unsigned(r_sqx)) + DEN_W'($unsigned(r_sqy));
        end
    end

    logic [CODE_W-1:0] w_code [0:2*NUM_PAIR-1];

    for (genvar j = 0; j < NUM_PAIR; j++) begin : g_pair
        logic signed [PROD_W-1:0] r_pxc, r_pys, r_pyc, r_pxs;
        logic signed [NUM_W-1:0]  r_nx, r_ny;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_px2[j] <= r_px[j];
                r_py2[j] <= r_py[j];
                r_pxc    <= r_px2[j] * r_cs;
                r_pys    <= r_py2[j] * r_sn;
                r_pyc    <= r_py2[j] * r_cs;
                r_pxs    <= r_px2[j] * r_sn;
                r_nx     <= NUM_W'(r_pxc) + NUM_W'(r_pys);
                r_ny     <= NUM_W'(r_pyc) - NUM_W'(r_pxs);
            end
        end

        qghc_div #(
            .FRAC_BITS (CODE_FRAC_BITS)
        ) u_div_x (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (r_nx),
            .i_den  (r_den),
            .o_code (w_code[2*j])
        );

        qghc_div #(
            .FRAC_BITS (CODE_FRAC_BITS)
        ) u_div_y (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (r_ny),
            .i_den  (r_den),
            .o_code (w_code[2*j+1])
        );

        // drop codes of stars not in use and of a degenerate frame
        logic w_keep;
        assign w_keep = !r_deg_pipe[LAT-1] && (r_n_pipe[LAT-1] > STARS_W'(j + 2));
        assign o_m_axis_tdata[2*j*CODE_W     +: CODE_W] = w_keep ? w_code[2*j]   : '0;
        assign o_m_axis_tdata[(2*j+1)*CODE_W +: CODE_W] = w_keep ? w_code[2*j+1] : '0;
    end

    assign o_m_axis_tuser[0] = r_deg_pipe[LAT-1];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == '0)
        else $error("degenerate quad with nonzero codes");

    a_unused_e: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (r_n_pipe[LAT-1] < 3'd5) |-> o_m_axis_tdata[143:96] == '0)
        else $error("star E code nonzero while not in use");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

endmodule : quad_geometric_hash_code_core

`default_nettype wire

// ----- rtl/qghc_div.sv -----
// ----------------------------------------------------------------------------
// qghc_div
// Pipelined signed fixed-point divider: round(num / den * 2^FRAC_BITS),
// ties away from zero, saturated to the signed code range. One quotient bit
// per quotient step stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qghc_div
    import qghc_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire                        i_clk,
    input  wire                        i_en,
    input  wire  signed [NUM_W-1:0]    i_num,
    input  wire         [DEN_W-1:0]    i_den,
    output logic        [CODE_W-1:0]   o_code
);

    localparam int NW  = NUM_W + FRAC_BITS + 1;   // scaled numerator width
    localparam int HW  = NW - QB;                 // bits above the quotient steps
    localparam int CW  = ((HW > DEN_W) ? HW : DEN_W) + 1;

    // magnitude stage
    logic [NUM_W-1:0] r_mag;
    logic             r_neg0;
    logic [DEN_W-1:0] r_den0;

    // range check stage and quotient steps
    logic [DEN_W-1:0] r_rem  [0:QB];
    logic [QB-1:0]    r_nlow [0:QB];
    logic [QB-1:0]    r_q    [0:QB];
    logic [DEN_W-1:0] r_den  [0:QB];
    logic             r_neg  [0:QB];
    logic             r_ovf  [0:QB];

    logic [NW-1:0]    w_scaled;
    logic [CW-1:0]    w_high;
    logic [CW-1:0]    w_den_ext;
    logic             w_ovf;
    logic [QB:0]      w_round;
    logic [QB-1:0]    w_val;

    assign w_scaled  = {r_mag, {(FRAC_BITS+1){1'b0}}};
    assign w_high    = CW'(w_scaled[NW-1:QB]);
    assign w_den_ext = CW'(r_den0);
    assign w_ovf     = (w_high >= w_den_ext);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg0 <= i_num[NUM_W-1];
            r_mag  <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_den0 <= i_den;

            // above the top of the code range: saturate, keep the chain quiet
            r_ovf[0]  <= w_ovf;
            r_rem[0]  <= w_ovf ? '0 : DEN_W'(w_high);
            r_nlow[0] <= w_scaled[QB-1:0];
            r_q[0]    <= '0;
            r_den[0]  <= r_den0;
            r_neg[0]  <= r_neg0;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [DEN_W:0] w_trial;
        logic           w_take;

        assign w_trial = {r_rem[k], r_nlow[k][QB-1]};
        assign w_take  = (w_trial >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_take ? DEN_W'(w_trial - {1'b0, r_den[k]})
                                      : w_trial[DEN_W-1:0];
                r_nlow[k+1] <= {r_nlow[k][QB-2:0], 1'b0};
                r_q[k+1]    <= {r_q[k][QB-2:0], w_take};
                r_den[k+1]  <= r_den[k];
                r_neg[k+1]  <= r_neg[k];
                r_ovf[k+1]  <= r_ovf[k];
            end
        end
    end

    // round half up on the magnitude, then saturate and apply the sign
    assign w_round = {1'b0, r_q[QB]} + (QB+1)'(1);
    assign w_val   = w_round[QB:1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[QB]) begin
                if (r_ovf[QB] || (w_val >= QB'(CODE_MIN))) begin
                    o_code <= CODE_MIN;
                end else begin
                    o_code <= CODE_W'(-w_val);
                end
            end else begin
                if (r_ovf[QB] || (w_val > QB'(CODE_MAX))) begin
                    o_code <= CODE_MAX;
                end else begin
                    o_code <= CODE_W'(w_val);
                end
            end
        end
    end

endmodule : qghc_div

`default_nettype wire

// ----- verif/tb_quad_geometric_hash_code_core.sv -----
// ----------------------------------------------------------------------------
// tb_quad_geometric_hash_code_core
// Self-checking bench: drives star quads on the slave stream, predicts each
// code beat with an in-bench fixed-point model, checks the master stream in
// order under random idling and back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_quad_geometric_hash_code_core;
    import qghc_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0] ey, ex, dy, dx, cy, cx;
    } t_codes;

    typedef struct {
        t_codes codes;
        logic   degen;
    } t_quad_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [STARS_W-1:0]  i_cfg_data;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [199:0]        i_s_axis_tdata;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [143:0]        o_m_axis_tdata;
    logic [0:0]          o_m_axis_tuser;

    quad_geometric_hash_code_core DUT (.*);

    // stars_in_use as the bench sees it (raw 3-bit register)
    logic [STARS_W-1:0]  stars_reg;
    t_quad_result        pending_codes[$];
    int                  mismatch_count;
    longint              cycle_count;
    bit                  sink_busy;      // stalls allowed on the master side
    int                  stall_left;     // cycles left in the current master stall

    localparam int CODE_FRAC = 16;
    localparam longint CYCLE_LIMIT = 400000;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Rounded, saturated num / den scaled by 2^CODE_FRAC.
    function automatic logic [CODE_W-1:0] scaled_quotient(longint num, longint den);
        longint unsigned mag, d, q, r, v, cap;
        bit neg;
        neg = num < 0;
        mag = neg ? -num : num;
        d = den;
        q = mag / d;
        r = mag % d;
        cap = 64'd1 << 25;
        v = (q > cap) ? cap : q;
        for (int i = 0; i < CODE_FRAC; i++) begin
            r = r << 1;
            v = v << 1;
            if (r >= d) begin
                r = r - d;
                v = v | 1;
            end
            if (v > cap) v = cap;
        end
        if ((r << 1) >= d) v = v + 1;
        if (neg) begin
            if (v >= 64'd8388608) return CODE_MIN;
            return CODE_W'(-v);
        end
        if (v > 64'd8388607) return CODE_MAX;
        return CODE_W'(v);
    endfunction

    function automatic t_quad_result hash_quad(logic [199:0] beat, logic [2:0] stars);
        t_quad_result res;
        longint crd[10];
        longint abx, aby, s, cs, sn, px, py;
        int n;
        logic [6*CODE_W-1:0] flat;
        flat = '0;
        res.degen = 1'b0;
        for (int i = 0; i < 10; i++) crd[i] = beat[i*COORD_W +: COORD_W];
        n = (stars < 3) ? 3 : (stars > 5) ? 5 : stars;
        abx = crd[2] - crd[0];
        aby = crd[3] - crd[1];
        if (abx == 0 && aby == 0) begin
            res.degen = 1'b1;
        end else begin
            s  = abx * abx + aby * aby;
            cs = aby + abx;
            sn = aby - abx;
            for (int i = 2; i < n; i++) begin
                px = crd[2*i] - crd[0];
                py = crd[2*i+1] - crd[1];
                flat[(2*(i-2))*CODE_W +: CODE_W]   = scaled_quotient(px*cs + py*sn, s);
                flat[(2*(i-2)+1)*CODE_W +: CODE_W] = scaled_quotient(py*cs - px*sn, s);
            end
        end
        res.codes = flat;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [CODE_W-1:0] got, logic [CODE_W-1:0] want);
        mismatch_count++;
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    endtask

    // Check each master beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_quad_result exp_q;
        t_codes got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_codes.size() == 0) begin
                report_mismatch("unexpected beat", '0, '0);
            end else begin
                exp_q = pending_codes.pop_front();
                got = o_m_axis_tdata;
                if (got.cx !== exp_q.codes.cx) report_mismatch("code_cx", got.cx, exp_q.codes.cx);
                if (got.cy !== exp_q.codes.cy) report_mismatch("code_cy", got.cy, exp_q.codes.cy);
                if (got.dx !== exp_q.codes.dx) report_mismatch("code_dx", got.dx, exp_q.codes.dx);
                if (got.dy !== exp_q.codes.dy) report_mismatch("code_dy", got.dy, exp_q.codes.dy);
                if (got.ex !== exp_q.codes.ex) report_mismatch("code_ex", got.ex, exp_q.codes.ex);
                if (got.ey !== exp_q.codes.ey) report_mismatch("code_ey", got.ey, exp_q.codes.ey);
                if (o_m_axis_tuser[0] !== exp_q.degen)
                    report_mismatch("degenerate", CODE_W'(o_m_axis_tuser),
                                    CODE_W'(exp_q.degen));
            end
        end
    end

    function automatic int random_gap(int long_max);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(4, long_max);
    endfunction

    // Master-side back-pressure: stall runs of random length, changed at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_left = 0;
        end else if (!sink_busy) begin
            i_m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < 30) stall_left = random_gap(30);
        end
    end

    // Send one quad beat, after a random idle gap if gapped; hold until accepted.
    // Valid stays high at the end so that the next beat can follow at once.
    task automatic send_quad(logic [199:0] beat, bit gapped);
        int gap;
        gap = gapped ? random_gap(20) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= beat;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_codes.push_back(hash_quad(beat, stars_reg));
        @(negedge i_clk);
    endtask

    // Drop valid, drain all outstanding beats, then let the pipeline settle.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_stars(logic [STARS_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        stars_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [199:0] pack_quad(logic [COORD_W-1:0] c[10]);
        logic [199:0] b;
        for (int i = 0; i < 10; i++) b[i*COORD_W +: COORD_W] = c[i];
        return b;
    endfunction

    function automatic logic [COORD_W-1:0] random_coord();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return COORD_W'($urandom_range(0, 20'hFFFFF));
    endfunction

    // Random quad: mostly stars near A, sometimes B equal to A, else fully random.
    function automatic logic [199:0] random_quad();
        logic [COORD_W-1:0] c[10];
        int span;
        int pick;
        pick = $urandom_range(0, 9);
        for (int i = 0; i < 10; i++) c[i] = random_coord();
        if (pick < 7) begin
            span = (pick < 3) ? 255 : 65535;
            for (int i = 2; i < 10; i++)
                c[i] = c[i%2] ^ COORD_W'($urandom_range(0, span));
        end else if (pick == 7) begin
            c[2] = c[0];
            c[3] = c[1];
        end
        return pack_quad(c);
    endfunction

    task automatic test_directed_extremes();
        logic [COORD_W-1:0] c[10];
        foreach (c[i]) c[i] = '0;
        send_quad(pack_quad(c), 1'b0);            // all zero: degenerate
        foreach (c[i]) c[i] = '1;
        send_quad(pack_quad(c), 1'b0);            // all max: degenerate
        c[0] = '0; c[1] = '0; c[2] = '1; c[3] = '1;
        send_quad(pack_quad(c), 1'b0);            // widest frame
        c[2] = 20'd1; c[3] = '0;                 // smallest frame: saturates
        c[4] = '1; c[5] = '0; c[6] = '0; c[7] = '1; c[8] = '1; c[9] = '1;
        send_quad(pack_quad(c), 1'b0);
        c[0] = '1; c[1] = '1; c[2] = 20'hFFFFE; c[3] = '1;
        c[4] = '0; c[5] = '0; c[6] = '1; c[7] = '0; c[8] = '0; c[9] = '1;
        send_quad(pack_quad(c), 1'b0);            // negative saturation
        // exact whole-number codes, including 1.0
        c[0] = 20'd100; c[1] = 20'd100; c[2] = 20'd101; c[3] = 20'd101;
        c[4] = 20'd101; c[5] = 20'd101; c[6] = 20'd100; c[7] = 20'd101;
        c[8] = 20'd102; c[9] = 20'd99;
        send_quad(pack_quad(c), 1'b0);
        c[2] = 20'd100 + 20'd3; c[3] = 20'd100;  // divisor 9: non-terminating
        send_quad(pack_quad(c), 1'b0);
        for (int i = 0; i < 6; i++) send_quad(random_quad(), 1'b1);
    endtask

    task automatic test_register_settings();
        logic [STARS_W-1:0] values[8] = '{3'd3, 3'd5, 3'd0, 3'd7, 3'd4, 3'd1, 3'd6, 3'd2};
        foreach (values[v]) begin
            write_stars(values[v]);
            for (int i = 0; i < 4; i++) send_quad(random_quad(), 1'b1);
        end
    endtask

    task automatic test_random_stream();
        logic [STARS_W-1:0] values[4] = '{3'd3, 3'd4, 3'd5, 3'd0};
        foreach (values[v]) begin
            write_stars(values[v]);
            sink_busy = (v != 1);
            for (int i = 0; i < 250; i++) send_quad(random_quad(), (v != 2));
        end
        sink_busy = 1'b1;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        stars_reg       = STARS_RESET;
        mismatch_count  = 0;
        cycle_count     = 0;
        sink_busy       = 1'b1;
        stall_left      = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_extremes();
        test_register_settings();
        test_random_stream();
        wait_drained();

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
